// ===== src/tgfsr_pkg.sv =====
// Shared types and constants for the twisted GFSR generator.
// No dependencies; every other file of the block uses this package.
package tgfsr_pkg;

  localparam int DATA_W    = 32;  // seed and result word width on the channels
  localparam int TWIST_W   = 32;
  localparam int MID_W     = 5;
  localparam int OB_W      = 6;
  localparam int CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TWIST    = 2'd0,
    CFG_MIDDLE   = 2'd1,
    CFG_OUT_BITS = 2'd2
  } cfg_idx_e;

  typedef enum logic {
    KIND_GEN  = 1'b0,
    KIND_SEED = 1'b1
  } kind_e;

  // write-back request from the generate stage to the word store
  typedef struct packed {
    logic              en;
    logic [DATA_W-1:0] data;
  } store_wr_t;

endpackage

// ===== src/tgfsr_in_if.sv =====
// Input channel: valid/ready handshake carrying one command item.
// Depends on tgfsr_pkg for the field widths.
interface tgfsr_in_if;
  logic                           valid;
  logic                           ready;
  logic                           kind;
  logic [tgfsr_pkg::DATA_W-1:0]   seed_word;

  modport source (output valid, output kind, output seed_word, input ready);
  modport sink   (input valid, input kind, input seed_word, output ready);
endinterface

// ===== src/tgfsr_out_if.sv =====
// Output channel: valid/ready handshake carrying one random word item.
// Depends on tgfsr_pkg for the field width.
interface tgfsr_out_if;
  logic                           valid;
  logic                           ready;
  logic [tgfsr_pkg::DATA_W-1:0]   random_word;

  modport source (output valid, output random_word, input ready);
  modport sink   (input valid, input random_word, output ready);
endinterface

// ===== src/tgfsr_store.sv =====
// Word store: circular buffer in a 2-read/1-write synchronous memory,
// fill count for reset-to-zero semantics, and one-deep write forwarding.
// Depends on tgfsr_pkg.
module tgfsr_store #(
  parameter int WORD_BITS = 32,
  parameter int NUM_WORDS = 25
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          rd_en_i,     // item accepted this cycle
  input  logic [tgfsr_pkg::MID_W-1:0]   middle_i,
  input  tgfsr_pkg::store_wr_t          wr_i,
  output logic [WORD_BITS-1:0]          oldest_o,
  output logic [WORD_BITS-1:0]          tap_o
);

  localparam int AW = $clog2(NUM_WORDS);
  localparam int CW = $clog2(NUM_WORDS + 1);
  localparam int MW = (AW > tgfsr_pkg::MID_W) ? AW : tgfsr_pkg::MID_W;

  logic [WORD_BITS-1:0] mem_q [NUM_WORDS];

  logic [AW-1:0]        wr_ptr_q, wr_ptr_d;
  logic [AW-1:0]        wr_addr_q;
  logic [CW-1:0]        cnt_q, cnt_d;

  logic [AW-1:0]        m_c;
  logic [MW-1:0]        m_ext;
  logic [AW:0]          tap_sum;
  logic [AW-1:0]        tap_addr;
  logic [CW:0]          vld_sum;
  logic                 tap_vld, old_vld;
  logic [WORD_BITS-1:0] wr_word;

  logic [WORD_BITS-1:0] rd_old_q, rd_tap_q, fwd_word_q;
  logic                 old_vld_q, tap_vld_q, old_hit_q, tap_hit_q;

  assign wr_word = wr_i.data[WORD_BITS-1:0];

  // Oldest word sits at the next write slot; the tap is m places newer.
  always_comb begin
    m_ext = MW'(middle_i);
    if (m_ext > MW'(NUM_WORDS - 1)) begin
      m_c = AW'(NUM_WORDS - 1);
    end else begin
      m_c = AW'(m_ext);
    end
    tap_sum = {1'b0, wr_ptr_q} + {1'b0, m_c};
    if (tap_sum >= (AW+1)'(NUM_WORDS)) begin
      tap_sum = tap_sum - (AW+1)'(NUM_WORDS);
    end
    tap_addr = tap_sum[AW-1:0];
    // entry of age k was written iff k < cnt; tap age is NUM_WORDS-1-m
    vld_sum  = (CW+1)'(m_c) + (CW+1)'(cnt_q);
    tap_vld  = (vld_sum >= (CW+1)'(NUM_WORDS));
    old_vld  = (cnt_q == CW'(NUM_WORDS));
  end

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    cnt_d    = cnt_q;
    if (rd_en_i) begin
      wr_ptr_d = (wr_ptr_q == AW'(NUM_WORDS - 1)) ? '0 : wr_ptr_q + 1'b1;
      if (!old_vld) begin
        cnt_d = cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_addr_q] <= wr_word;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_old_q   <= mem_q[wr_ptr_q];
      rd_tap_q   <= mem_q[tap_addr];
      old_vld_q  <= old_vld;
      tap_vld_q  <= tap_vld;
      // a write landing at the same edge is missed by the read
      old_hit_q  <= wr_i.en && (wr_addr_q == wr_ptr_q);
      tap_hit_q  <= wr_i.en && (wr_addr_q == tap_addr);
      fwd_word_q <= wr_word;
      wr_addr_q  <= wr_ptr_q;
    end
  end

  always_comb begin
    oldest_o = old_hit_q ? fwd_word_q : (old_vld_q ? rd_old_q : '0);
    tap_o    = tap_hit_q ? fwd_word_q : (tap_vld_q ? rd_tap_q : '0);
  end

  a_ptr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_ptr_q <= AW'(NUM_WORDS - 1))
    else $error("write pointer out of range");

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(NUM_WORDS))
    else $error("fill count above depth");

  a_cnt_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_en_i && (cnt_q != CW'(NUM_WORDS)) |=> cnt_q == $past(cnt_q) + 1'b1)
    else $error("fill count missed an item");

endmodule

// ===== src/tgfsr_gen.sv =====
// Generate stage: forms the twisted word from the store's read data,
// writes it back, and holds the masked result in the output register.
// Depends on tgfsr_pkg and tgfsr_out_if.
module tgfsr_gen #(
  parameter int WORD_BITS = 32
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            accept_i,
  input  logic                            kind_i,
  input  logic [tgfsr_pkg::DATA_W-1:0]    seed_i,
  input  logic [WORD_BITS-1:0]            oldest_i,
  input  logic [WORD_BITS-1:0]            tap_i,
  input  logic [tgfsr_pkg::TWIST_W-1:0]   twist_i,
  input  logic [tgfsr_pkg::OB_W-1:0]      out_bits_i,
  output logic                            ready_o,
  output tgfsr_pkg::store_wr_t            wr_o,
  tgfsr_out_if.source                     out_ch
);

  logic                          s2_valid_q, s2_valid_d;
  logic                          s2_kind_q;
  logic [WORD_BITS-1:0]          s2_seed_q;
  logic                          out_valid_q, out_valid_d;
  logic [tgfsr_pkg::DATA_W-1:0]  out_word_q;

  logic                          is_seed, advance;
  logic [WORD_BITS-1:0]          new_word;
  logic [tgfsr_pkg::OB_W-1:0]    ob;
  logic [tgfsr_pkg::DATA_W-1:0]  keep, masked;

  assign is_seed = (s2_kind_q == tgfsr_pkg::KIND_SEED);
  assign advance = s2_valid_q && (is_seed || !out_valid_q || out_ch.ready);
  assign ready_o = !s2_valid_q || advance;

  always_comb begin
    new_word = tap_i ^ (oldest_i >> 1);
    if (oldest_i[0]) begin
      new_word = new_word ^ twist_i[WORD_BITS-1:0];
    end
  end

  always_comb begin
    ob = (out_bits_i > tgfsr_pkg::OB_W'(WORD_BITS)) ? tgfsr_pkg::OB_W'(WORD_BITS)
                                                    : out_bits_i;
    for (int i = 0; i < tgfsr_pkg::DATA_W; i++) begin
      keep[i] = (i < WORD_BITS) && (i >= WORD_BITS - int'(ob));
    end
    masked = tgfsr_pkg::DATA_W'(new_word) & keep;
  end

  always_comb begin
    wr_o.en   = advance;
    wr_o.data = is_seed ? tgfsr_pkg::DATA_W'(s2_seed_q)
                        : tgfsr_pkg::DATA_W'(new_word);
  end

  always_comb begin
    s2_valid_d = s2_valid_q;
    if (accept_i) begin
      s2_valid_d = 1'b1;
    end else if (advance) begin
      s2_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (advance && !is_seed) begin
      out_valid_d = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s2_valid_q  <= s2_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      s2_kind_q <= kind_i;
      s2_seed_q <= seed_i[WORD_BITS-1:0];
    end
    if (advance && !is_seed) begin
      out_word_q <= masked;
    end
  end

  assign out_ch.valid       = out_valid_q;
  assign out_ch.random_word = out_word_q;

  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i |-> ready_o)
    else $error("item accepted while stage busy");

  a_wr_has_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_o.en |-> s2_valid_q)
    else $error("write-back without an item in stage");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_valid_q && !is_seed && out_valid_q && !out_ch.ready
      |=> s2_valid_q && $stable(s2_kind_q))
    else $error("stalled generate item lost");

endmodule

// ===== src/twisted_gfsr_generator_unit.sv =====
// Twisted GFSR random word generator, top level.
// Depends on tgfsr_pkg, tgfsr_in_if, tgfsr_out_if, tgfsr_store, tgfsr_gen.
//
// Usage:
//   in_ch_i  : command items. kind = 1 shifts seed_word in as the newest
//              word and returns nothing; kind = 0 generates one word.
//   out_ch_o : one random_word item for every generate item, in order.
//   cfg_*    : write twist word (0), tap distance (1), out bits (2) while idle.
// A generate item passes the synchronous read of the word memory, then
// the twist and write-back, into the output register on out_ch_o.
// Throughput: one item per clock while out_ch_o does not stall; the memory
// reads the oldest and tap words while the previous item writes back, and
// a one-entry forward covers a read of the word written at the same edge.
// Reset: all stored words read as zero (fill count, no clearing pass);
// registers return to their reset values. When out_ch_o stalls, one result
// waits in the output register, one item waits in the generate stage, and
// in_ch_i drops ready until the stage can move; seed items never wait on
// the output side.
module twisted_gfsr_generator_unit #(
  parameter int WORD_BITS = 32,
  parameter int NUM_WORDS = 25
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [tgfsr_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [tgfsr_pkg::TWIST_W-1:0]      cfg_data_i,
  tgfsr_in_if.sink                           in_ch_i,
  tgfsr_out_if.source                        out_ch_o
);

  logic [tgfsr_pkg::TWIST_W-1:0] twist_q;
  logic [tgfsr_pkg::MID_W-1:0]   middle_q;
  logic [tgfsr_pkg::OB_W-1:0]    out_bits_q;

  logic                          accept, stage_ready;
  tgfsr_pkg::store_wr_t          wr;
  logic [WORD_BITS-1:0]          oldest, tap;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      twist_q    <= 32'h8EBF_D028;
      middle_q   <= 5'd7;
      out_bits_q <= 6'd32;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        tgfsr_pkg::CFG_TWIST:    twist_q    <= cfg_data_i;
        tgfsr_pkg::CFG_MIDDLE:   middle_q   <= cfg_data_i[tgfsr_pkg::MID_W-1:0];
        tgfsr_pkg::CFG_OUT_BITS: out_bits_q <= cfg_data_i[tgfsr_pkg::OB_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_ch_i.ready = stage_ready;
  assign accept        = in_ch_i.valid && stage_ready;

  tgfsr_store #(
    .WORD_BITS (WORD_BITS),
    .NUM_WORDS (NUM_WORDS)
  ) u_store (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .rd_en_i  (accept),
    .middle_i (middle_q),
    .wr_i     (wr),
    .oldest_o (oldest),
    .tap_o    (tap)
  );

  tgfsr_gen #(
    .WORD_BITS (WORD_BITS)
  ) u_gen (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .kind_i     (in_ch_i.kind),
    .seed_i     (in_ch_i.seed_word),
    .oldest_i   (oldest),
    .tap_i      (tap),
    .twist_i    (twist_q),
    .out_bits_i (out_bits_q),
    .ready_o    (stage_ready),
    .wr_o       (wr),
    .out_ch     (out_ch_o)
  );

endmodule
